// ----- rtl/mvr_pkg.sv -----
package mvr_pkg;

  // Field widths
  localparam int DIST_W   = 32;
  localparam int DRIVE_W  = 16;
  localparam int CAP_W    = 15;
  localparam int TICK_W   = 16;
  localparam int MPT_W    = 24;
  localparam int TRAVEL_W = DIST_W + 1;
  localparam int STEP_W   = 12;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Distance thresholds, Q15.16 metres
  localparam logic [DIST_W-1:0] DIST_NEAR = 32'd6554;  // 0.1 m
  localparam logic [DIST_W-1:0] DIST_STOP = 32'd655;   // 0.01 m

  // Drive constants, Q2.14
  localparam logic [DRIVE_W-1:0] DRIVE_BRAKE_MIN  = 16'd3277;  // 0.2
  localparam logic [STEP_W-1:0]  DRIVE_BRAKE_STEP = 12'd1638;  // 0.1
  localparam logic [STEP_W-1:0]  DRIVE_RAMP_STEP  = 12'd164;   // 0.01
  localparam logic [CAP_W-1:0]   CAP_RESET        = 15'd8192;  // 0.5

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  // Register word index (paddr[2])
  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_MPT    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             enable;
    logic [MPT_W-1:0] mpt;
  } cfg_t;

  // Input register contents: travel already scaled
  typedef struct packed {
    logic                       load;
    logic signed [TRAVEL_W-1:0] left_travel;
    logic signed [TRAVEL_W-1:0] right_travel;
    logic signed [DIST_W-1:0]   left_target;
    logic signed [DIST_W-1:0]   right_target;
    logic [CAP_W-1:0]           left_limit;
    logic [CAP_W-1:0]           right_limit;
  } s1_t;

  // Remaining distance minus travel, saturated to 32 bits
  function automatic logic signed [DIST_W-1:0] dist_sub(
    input logic signed [DIST_W-1:0]   d,
    input logic signed [TRAVEL_W-1:0] t
  );
    logic signed [DIST_W+1:0] diff;
    diff = {{2{d[DIST_W-1]}}, d} - {t[TRAVEL_W-1], t};
    if (diff[DIST_W+1:DIST_W-1] == 3'b000 || diff[DIST_W+1:DIST_W-1] == 3'b111) begin
      return diff[DIST_W-1:0];
    end else if (diff[DIST_W+1]) begin
      return {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DIST_W-1){1'b1}}};
    end
  endfunction

  // Magnitude; the most negative value maps to 2^(W-1) unsigned
  function automatic logic [DIST_W-1:0] abs_dist(input logic signed [DIST_W-1:0] d);
    return d[DIST_W-1] ? DIST_W'(~d + 1'b1) : d;
  endfunction

  function automatic logic [DRIVE_W-1:0] abs_drive(input logic signed [DRIVE_W-1:0] v);
    return v[DRIVE_W-1] ? DRIVE_W'(~v + 1'b1) : v;
  endfunction

  // drive + sign(dist)*step (or minus when negate), saturated to 16 bits
  function automatic logic signed [DRIVE_W-1:0] drive_step(
    input logic signed [DRIVE_W-1:0] drv,
    input logic signed [DIST_W-1:0]  dist_val,
    input logic [STEP_W-1:0]         step,
    input logic                      negate
  );
    logic signed [DRIVE_W:0] delta;
    logic signed [DRIVE_W:0] sum;
    delta = $signed({{(DRIVE_W+1-STEP_W){1'b0}}, step});
    if (dist_val == '0) begin
      delta = '0;
    end else if (dist_val[DIST_W-1] ^ negate) begin
      delta = -delta;
    end
    sum = {drv[DRIVE_W-1], drv} + delta;
    if (sum[DRIVE_W] != sum[DRIVE_W-1]) begin
      return sum[DRIVE_W] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end
    return sum[DRIVE_W-1:0];
  endfunction

endpackage

// ----- rtl/mvr_in_if.sv -----
interface mvr_in_if;
  import mvr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TICK_W-1:0] left_ticks;
  logic signed [TICK_W-1:0] right_ticks;
  logic signed [DIST_W-1:0] left_target;
  logic signed [DIST_W-1:0] right_target;
  logic [CAP_W-1:0]         left_limit;
  logic [CAP_W-1:0]         right_limit;

  modport source (
    output valid, cmd, left_ticks, right_ticks, left_target, right_target,
           left_limit, right_limit,
    input  ready
  );

  modport sink (
    input  valid, cmd, left_ticks, right_ticks, left_target, right_target,
           left_limit, right_limit,
    output ready
  );
endinterface

// ----- rtl/mvr_out_if.sv -----
interface mvr_out_if;
  import mvr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      ready_res;

  modport source (
    output valid, left_drive, right_drive, ready_res,
    input  ready
  );

  modport sink (
    input  valid, left_drive, right_drive, ready_res,
    output ready
  );
endinterface

// ----- rtl/mvr_cfg.sv -----
module mvr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvr_pkg::PADDR_W-1:0]  paddr,
  input  logic [mvr_pkg::PDATA_W-1:0]  pwdata,
  output logic [mvr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output mvr_pkg::cfg_t                cfg
);
  import mvr_pkg::*;

  logic             enable_r;
  logic [MPT_W-1:0] mpt_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      mpt_r    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE: enable_r <= pwdata[0];
        REG_MPT:    mpt_r    <= pwdata[MPT_W-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, enable_r};
      REG_MPT:    prdata = {{(PDATA_W-MPT_W){1'b0}}, mpt_r};
    endcase
  end

  assign cfg.enable = enable_r;
  assign cfg.mpt    = mpt_r;
endmodule

// ----- rtl/mvr_scale.sv -----
module mvr_scale (
  input  logic signed [mvr_pkg::TICK_W-1:0]   ticks,
  input  logic [mvr_pkg::MPT_W-1:0]           mpt,
  output logic signed [mvr_pkg::TRAVEL_W-1:0] travel
);
  import mvr_pkg::*;

  localparam int PROD_W = TICK_W + MPT_W;

  logic [TICK_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [DIST_W-1:0] q;

  // |ticks| * metres_per_tick, Q.24 rounded to Q.16, sign restored
  assign mag     = ticks[TICK_W-1] ? TICK_W'(~ticks + 1'b1) : ticks;
  assign prod    = PROD_W'(mag) * PROD_W'(mpt);
  assign rounded = prod + PROD_W'(128);
  assign q       = rounded[DIST_W+7:8];
  assign travel  = ticks[TICK_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule

// ----- rtl/mvr_core.sv -----
module mvr_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic                               enable,
  input  mvr_pkg::s1_t                       item,
  output logic signed [mvr_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [mvr_pkg::DRIVE_W-1:0] right_drive,
  output logic                               done
);
  import mvr_pkg::*;

  logic signed [DIST_W-1:0]  left_rem_r,  left_rem_nxt;
  logic signed [DIST_W-1:0]  right_rem_r, right_rem_nxt;
  logic signed [DRIVE_W-1:0] left_drive_r,  left_drive_nxt;
  logic signed [DRIVE_W-1:0] right_drive_r, right_drive_nxt;
  logic [CAP_W-1:0]          left_cap_r,  left_cap_nxt;
  logic [CAP_W-1:0]          right_cap_r, right_cap_nxt;
  logic                      done_r, done_nxt;

  // One tick or load, in file order
  always_comb begin
    logic signed [DIST_W-1:0]  l_new;
    logic signed [DIST_W-1:0]  r_new;
    logic [DIST_W-1:0]         al;
    logic [DIST_W-1:0]         ar_old;
    logic [DIST_W-1:0]         ar_new;
    logic signed [DRIVE_W-1:0] ld;
    logic signed [DRIVE_W-1:0] rd;

    left_rem_nxt    = left_rem_r;
    right_rem_nxt   = right_rem_r;
    left_drive_nxt  = left_drive_r;
    right_drive_nxt = right_drive_r;
    left_cap_nxt    = left_cap_r;
    right_cap_nxt   = right_cap_r;
    done_nxt        = done_r;

    l_new  = dist_sub(left_rem_r, item.left_travel);
    r_new  = dist_sub(right_rem_r, item.right_travel);
    al     = abs_dist(l_new);
    ar_old = abs_dist(right_rem_r);
    ar_new = abs_dist(r_new);
    ld     = left_drive_r;
    rd     = right_drive_r;

    // Brake near the goal; right still uses its old distance
    if (al <= DIST_NEAR && abs_drive(ld) > DRIVE_BRAKE_MIN) begin
      ld = drive_step(ld, l_new, DRIVE_BRAKE_STEP, 1'b0);
    end
    if (ar_old <= DIST_NEAR && abs_drive(rd) > DRIVE_BRAKE_MIN) begin
      rd = drive_step(rd, right_rem_r, DRIVE_BRAKE_STEP, 1'b1);
    end
    // Stop at the goal
    if (al <= DIST_STOP) begin
      ld = '0;
    end
    if (ar_old <= DIST_STOP) begin
      rd = '0;
    end
    // Ramp toward the cap; left is inverted
    if (ar_new >= DIST_NEAR && abs_drive(rd) < {1'b0, right_cap_r}) begin
      rd = drive_step(rd, r_new, DRIVE_RAMP_STEP, 1'b0);
    end
    if (al >= DIST_NEAR && abs_drive(ld) < {1'b0, left_cap_r}) begin
      ld = drive_step(ld, l_new, DRIVE_RAMP_STEP, 1'b1);
    end

    if (enable) begin
      if (item.load) begin
        left_rem_nxt  = item.left_target;
        right_rem_nxt = item.right_target;
        left_cap_nxt  = item.left_limit;
        right_cap_nxt = item.right_limit;
      end else begin
        left_rem_nxt    = l_new;
        right_rem_nxt   = r_new;
        left_drive_nxt  = ld;
        right_drive_nxt = rd;
        done_nxt        = (al <= DIST_NEAR) && (ar_new <= DIST_NEAR);
      end
    end
  end

  // State doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rem_r    <= '0;
      right_rem_r   <= '0;
      left_drive_r  <= '0;
      right_drive_r <= '0;
      left_cap_r    <= CAP_RESET;
      right_cap_r   <= CAP_RESET;
      done_r        <= 1'b0;
    end else if (step) begin
      left_rem_r    <= left_rem_nxt;
      right_rem_r   <= right_rem_nxt;
      left_drive_r  <= left_drive_nxt;
      right_drive_r <= right_drive_nxt;
      left_cap_r    <= left_cap_nxt;
      right_cap_r   <= right_cap_nxt;
      done_r        <= done_nxt;
    end
  end

  assign left_drive  = left_drive_r;
  assign right_drive = right_drive_r;
  assign done        = done_r;
endmodule

// ----- rtl/two_wheel_move_ramp.sv -----
// Channel   Dir  Handshake        Carries
// in_ch     in   valid/ready      cmd, ticks, targets, limits
// out_ch    out  valid/ready      left_drive, right_drive, ready_res
// cfg       in   APB (psel..)     enable @0x0, metres_per_tick @0x4
//
// One transaction per cycle sustained unless the result stalls.
// Stage one registers the input with the tick-to-metre product; stage two
// updates the wheel state, which is also the result register.
// Reset (rst_n low, synchronous) empties both stages; caps return to 0.5.
// A stalled result holds; the input register still fills, then ready drops.
module two_wheel_move_ramp (
  input  logic                         clk,
  input  logic                         rst_n,
  mvr_in_if.sink                       in_ch,
  mvr_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvr_pkg::PADDR_W-1:0]  paddr,
  input  logic [mvr_pkg::PDATA_W-1:0]  pwdata,
  output logic [mvr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mvr_pkg::*;

  cfg_t cfg;
  s1_t  s1_r, s1_nxt;
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  mvr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scale encoder counts on the way into stage one
  mvr_scale u_scale_l (
    .ticks  (in_ch.left_ticks),
    .mpt    (cfg.mpt),
    .travel (s1_nxt.left_travel)
  );

  mvr_scale u_scale_r (
    .ticks  (in_ch.right_ticks),
    .mpt    (cfg.mpt),
    .travel (s1_nxt.right_travel)
  );

  assign s1_nxt.load         = (in_ch.cmd == CMD_LOAD);
  assign s1_nxt.left_target  = in_ch.left_target;
  assign s1_nxt.right_target = in_ch.right_target;
  assign s1_nxt.left_limit   = in_ch.left_limit;
  assign s1_nxt.right_limit  = in_ch.right_limit;

  // Pipeline handshake
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  mvr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r && s1_adv),
    .enable      (cfg.enable),
    .item        (s1_r),
    .left_drive  (out_ch.left_drive),
    .right_drive (out_ch.right_drive),
    .done        (out_ch.ready_res)
  );

  assign out_ch.valid = out_valid_r;
endmodule

// ----- rtl/mvr_checker.sv -----
module mvr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mvr_pkg::DRIVE_W-1:0] left_drive,
  input logic signed [mvr_pkg::DRIVE_W-1:0] right_drive,
  input logic                               ready_res
);
  import mvr_pkg::*;

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipe not empty after reset");

  // Empty result register never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Every accepted transaction shows a result after stage one and stage two
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after accepted transaction");

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_drive)
      && $stable(right_drive) && $stable(ready_res))
    else $error("stalled result changed");
endmodule

bind two_wheel_move_ramp mvr_checker u_mvr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_drive  (out_ch.left_drive),
  .right_drive (out_ch.right_drive),
  .ready_res   (out_ch.ready_res)
);
